// ===== rtl/core/csem_pkg.sv =====
// Package for the counting semaphore with priority waiters.
// Holds table size, operation and status codes, shared types.
// No dependencies.
package csem_pkg;
	localparam int WaiterSlots = 16;
	localparam int SlotW = $clog2(WaiterSlots);
	localparam int TotW = $clog2(WaiterSlots + 1);

	localparam logic [1:0] OP_WAIT = 2'd0;
	localparam logic [1:0] OP_TRY = 2'd1;
	localparam logic [1:0] OP_POST = 2'd2;
	localparam logic [1:0] OP_CANCEL = 2'd3;

	localparam logic [2:0] ST_ACQUIRED = 3'd0;
	localparam logic [2:0] ST_ENQUEUED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_CNT_FULL = 3'd4;
	localparam logic [2:0] ST_REMOVED = 3'd5;
	localparam logic [2:0] ST_NOT_FOUND = 3'd6;
	localparam logic [2:0] ST_WOKE = 3'd7;

	localparam logic [1:0] REG_INIT = 2'd0;
	localparam logic [1:0] REG_MAX = 2'd1;
	localparam logic [1:0] REG_PIP = 2'd2;

	typedef struct packed {
		logic [7:0] id;
		logic [15:0] gen;
		logic [7:0] prio;
	} waiter_t;
endpackage

// ===== rtl/core/csem_table.sv =====
// Waiter table storage for the counting semaphore.
// Uses csem_pkg; one write port and one registered read port.
module csem_table import csem_pkg::*; (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [SlotW-1:0] wr_addr,
	input  waiter_t          wr_data,
	input  logic [SlotW-1:0] rd_addr,
	output waiter_t          rd_data
);
	waiter_t mem_q [WaiterSlots];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== rtl/core/counting_semaphore_priority_waiters.sv =====
// Counting semaphore with a 16-slot priority waiter table and priority inheritance.
// Uses csem_pkg and csem_table.
//
// One request is taken while busy is low; its single result appears for one cycle
// with done high. The receiver cannot stall results. Wait and try-wait on a free
// unit, post without waiters, and a full-table wait do not scan the table. An enqueue
// with inheritance, a post that wakes a waiter, and a cancel step through the table
// one entry per cycle over its single read port. A cancel that finds its entry and a
// wake then move the last entry into the freed slot. A wake that must restore an
// inherited priority then rescans the remaining table. Configuration writes are
// taken only while idle and no request is offered.
module counting_semaphore_priority_waiters import csem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  task_id,
	input  logic [15:0] task_generation,
	input  logic [7:0]  task_priority,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic        woken_valid,
	output logic [7:0]  woken_task,
	output logic        owner_valid,
	output logic [7:0]  owner_task,
	output logic [7:0]  owner_priority,
	output logic        priority_changed
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_RSCAN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [15:0] max_q, count_q;
	logic pip_q;
	logic [TotW-1:0] total_q;
	logic own_q, sv_q;
	logic [7:0] oid_q, oprio_q, sprio_q;
	logic [1:0] op_q;
	logic [7:0] id_q, prio_q, best_prio_q, top_q;
	logic [15:0] gen_q;
	logic [TotW-1:0] idx_q;
	logic [SlotW-1:0] best_q;
	logic found_q, pend_q;
	logic [2:0] st_q;
	logic wv_q, chg_q;
	logic [7:0] wt_q;
	logic [SlotW-1:0] rd_addr, wr_addr;
	logic wr_en;
	waiter_t wr_data, rd_data;
	logic [TotW-1:0] last;
	logic [SlotW-1:0] cur;
	logic [7:0] nxt_top;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy && !start;
	assign last = total_q - 1'b1;
	assign cur = SlotW'(idx_q - 1'b1);
	assign nxt_top = (idx_q != 0 && rd_data.prio > top_q) ? rd_data.prio : top_q;

	always_comb begin
		rd_addr = idx_q[SlotW-1:0];
		if (state_q == S_FETCH) rd_addr = last[SlotW-1:0];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = total_q[SlotW-1:0];
		wr_data = '{id: id_q, gen: gen_q, prio: prio_q};
		if (state_q == S_MOVE) begin
			wr_en = 1'b1;
			wr_addr = best_q;
			wr_data = rd_data;
		end else if (state_q == S_DONE && pend_q) begin
			wr_en = 1'b1;
		end
	end

	csem_table u_table (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= 16'd1; pip_q <= 1'b1; count_q <= '0;
			total_q <= '0; own_q <= 1'b0; oid_q <= '0; oprio_q <= '0;
			sprio_q <= '0; sv_q <= 1'b0; done <= 1'b0; pend_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INIT: count_q <= cfg_data;
					REG_MAX: max_q <= cfg_data;
					REG_PIP: pip_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					op_q <= operation; id_q <= task_id; gen_q <= task_generation;
					prio_q <= task_priority; wv_q <= 1'b0; wt_q <= '0; chg_q <= 1'b0;
					pend_q <= 1'b0; idx_q <= '0; found_q <= 1'b0; best_q <= '0;
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_DONE;
					case (op_q)
						OP_WAIT: if (count_q != 0) begin
							count_q <= count_q - 1'b1; st_q <= ST_ACQUIRED;
							if (count_q == 16'd1) begin
								own_q <= 1'b1; oid_q <= id_q; oprio_q <= prio_q;
							end
						end else if (total_q >= TotW'(WaiterSlots)) begin
							st_q <= ST_FULL;
						end else begin
							st_q <= ST_ENQUEUED; pend_q <= 1'b1; top_q <= prio_q;
							if (pip_q && own_q) begin
								idx_q <= '0; state_q <= S_SCAN;
							end
						end
						OP_TRY: if (count_q != 0) begin
							count_q <= count_q - 1'b1; st_q <= ST_ACQUIRED;
						end else st_q <= ST_EMPTY;
						OP_POST: if (total_q != 0) begin
							st_q <= ST_WOKE; best_prio_q <= '0; state_q <= S_SCAN;
						end else if (count_q < max_q) begin
							if (count_q == 0) own_q <= 1'b0;
							count_q <= count_q + 1'b1; st_q <= ST_ACQUIRED;
						end else st_q <= ST_CNT_FULL;
						default: begin
							st_q <= ST_NOT_FOUND;
							if (total_q != 0) state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					// idx_q is the address being read; rd_data holds entry idx_q-1
					if (idx_q != 0) begin
						case (op_q)
							OP_WAIT: if (rd_data.prio > top_q) top_q <= rd_data.prio;
							OP_POST: if (idx_q == 1 || rd_data.prio > best_prio_q) begin
								best_prio_q <= rd_data.prio; best_q <= cur;
								wt_q <= rd_data.id;
							end
							default: if (!found_q && rd_data.id == id_q &&
									rd_data.gen == gen_q) begin
								found_q <= 1'b1; best_q <= cur;
							end
						endcase
					end
					if (idx_q == total_q) begin
						if (op_q == OP_WAIT) begin
							state_q <= S_DONE;
							if (nxt_top > oprio_q) begin
								if (!sv_q) begin sv_q <= 1'b1; sprio_q <= oprio_q; end
								oprio_q <= nxt_top;
								chg_q <= 1'b1;
							end
						end else if (op_q == OP_POST ||
								found_q || (rd_data.id == id_q && rd_data.gen == gen_q)) begin
							state_q <= S_FETCH;
						end else state_q <= S_DONE;
					end else idx_q <= idx_q + 1'b1;
				end
				S_FETCH: state_q <= S_MOVE;
				S_MOVE: begin
					total_q <= last;
					if (op_q == OP_POST) begin
						wv_q <= 1'b1;
						if (pip_q && own_q && sv_q) begin
							idx_q <= '0; top_q <= '0; state_q <= S_RSCAN;
						end else state_q <= S_DONE;
					end else begin
						st_q <= ST_REMOVED; state_q <= S_DONE;
					end
				end
				S_RSCAN: begin
					if (idx_q != 0 && rd_data.prio > top_q) top_q <= rd_data.prio;
					if (idx_q == total_q) begin
						state_q <= S_DONE;
						if (idx_q != 0 && rd_data.prio > top_q) begin
							if (rd_data.prio > sprio_q) begin
								oprio_q <= rd_data.prio; chg_q <= (rd_data.prio != oprio_q);
							end else begin
								oprio_q <= sprio_q; sv_q <= 1'b0; chg_q <= (sprio_q != oprio_q);
							end
						end else if (top_q > sprio_q) begin
							oprio_q <= top_q; chg_q <= (top_q != oprio_q);
						end else begin
							oprio_q <= sprio_q; sv_q <= 1'b0; chg_q <= (sprio_q != oprio_q);
						end
					end else idx_q <= idx_q + 1'b1;
				end
				S_DONE: begin
					if (pend_q) total_q <= total_q + 1'b1;
					pend_q <= 1'b0;
					done <= 1'b1;
					status <= st_q;
					woken_valid <= wv_q;
					woken_task <= wv_q ? wt_q : 8'd0;
					owner_valid <= own_q;
					owner_task <= own_q ? oid_q : 8'd0;
					owner_priority <= own_q ? oprio_q : 8'd0;
					priority_changed <= chg_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TotW'(WaiterSlots)) else $error("waiter total overflow");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done while busy");
	a_woke_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_WOKE) |-> woken_valid) else $error("wake without task");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule

// ===== test/counting_semaphore_priority_waiters_tb.sv =====
// Testbench for the counting semaphore with priority waiters.
// Drives random and directed requests and register writes, checks each result word
// against a behavioral model in a scoreboard class. Depends on csem_pkg and the RTL.
module counting_semaphore_priority_waiters_tb;
	import csem_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic woken_valid;
		logic [7:0] woken_task;
		logic owner_valid;
		logic [7:0] owner_task;
		logic [7:0] owner_priority;
		logic priority_changed;
	} sem_result_t;

	class sem_scoreboard;
		logic [15:0] init_cnt, max_cnt;
		logic pip_on;
		logic [15:0] units;
		int total;
		waiter_t slots[WaiterSlots];
		logic own_v;
		logic [7:0] own_id, own_pr, save_pr;
		logic save_v;
		sem_result_t pending[$];
		int errors, checked;

		function new();
			init_cnt = 0;
			max_cnt = 1;
			pip_on = 1;
			units = 0;
			total = 0;
			own_v = 0;
			own_id = 0;
			own_pr = 0;
			save_pr = 0;
			save_v = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == REG_INIT) begin
				init_cnt = val;
				units = val;
			end else if (idx == REG_MAX) begin
				max_cnt = val;
			end else if (idx == REG_PIP) begin
				pip_on = val[0];
			end
		endfunction

		function logic [7:0] top_prio(logic [7:0] floor_pr);
			logic [7:0] b;
			b = floor_pr;
			for (int i = 0; i < total; i++)
				if (slots[i].prio > b)
					b = slots[i].prio;
			return b;
		endfunction

		function void remove_slot(int s);
			slots[s] = slots[total - 1];
			total--;
		endfunction

		function void note_request(logic [1:0] op, logic [7:0] id, logic [15:0] gen,
				logic [7:0] pr);
			sem_result_t r;
			logic [7:0] t, was;
			int b;
			r = '{default: 0};
			case (op)
				OP_WAIT: begin
					if (units > 0) begin
						units--;
						if (units == 0) begin
							own_v = 1;
							own_id = id;
							own_pr = pr;
						end
						r.status = ST_ACQUIRED;
					end else if (total >= WaiterSlots) begin
						r.status = ST_FULL;
					end else begin
						if (pip_on && own_v) begin
							t = top_prio(pr);
							if (t > own_pr) begin
								if (!save_v) begin
									save_pr = own_pr;
									save_v = 1;
								end
								own_pr = t;
								r.priority_changed = 1;
							end
						end
						slots[total] = '{id: id, gen: gen, prio: pr};
						total++;
						r.status = ST_ENQUEUED;
					end
				end
				OP_TRY: begin
					if (units > 0) begin
						units--;
						r.status = ST_ACQUIRED;
					end else begin
						r.status = ST_EMPTY;
					end
				end
				OP_POST: begin
					if (total > 0) begin
						b = 0;
						for (int i = 1; i < total; i++)
							if (slots[i].prio > slots[b].prio)
								b = i;
						r.woken_valid = 1;
						r.woken_task = slots[b].id;
						remove_slot(b);
						if (pip_on && own_v && save_v) begin
							was = own_pr;
							t = top_prio(0);
							if (t > save_pr) begin
								own_pr = t;
							end else begin
								own_pr = save_pr;
								save_v = 0;
							end
							r.priority_changed = own_pr != was;
						end
						r.status = ST_WOKE;
					end else if (units < max_cnt) begin
						if (units == 0)
							own_v = 0;
						units++;
						r.status = ST_ACQUIRED;
					end else begin
						r.status = ST_CNT_FULL;
					end
				end
				default: begin
					r.status = ST_NOT_FOUND;
					for (int i = 0; i < total; i++) begin
						if (slots[i].id == id && slots[i].gen == gen) begin
							remove_slot(i);
							r.status = ST_REMOVED;
							break;
						end
					end
				end
			endcase
			r.owner_valid = own_v;
			r.owner_task = own_v ? own_id : 8'd0;
			r.owner_priority = own_v ? own_pr : 8'd0;
			pending.push_back(r);
		endfunction

		function void check_result(sem_result_t got);
			sem_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: status %0d", got.status);
				return;
			end
			e = pending.pop_front();
			if (got != e) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp st%0d wv%0d wt%0d ov%0d ot%0d op%0d pc%0d",
						" got st%0d wv%0d wt%0d ov%0d ot%0d op%0d pc%0d"},
						e.status, e.woken_valid, e.woken_task, e.owner_valid,
						e.owner_task, e.owner_priority, e.priority_changed,
						got.status, got.woken_valid, got.woken_task, got.owner_valid,
						got.owner_task, got.owner_priority, got.priority_changed);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] operation = OP_WAIT;
	logic [7:0] task_id = 0;
	logic [15:0] task_generation = 0;
	logic [7:0] task_priority = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_INIT;
	logic [15:0] cfg_data = 0;
	logic done;
	logic [2:0] status;
	logic woken_valid;
	logic [7:0] woken_task;
	logic owner_valid;
	logic [7:0] owner_task;
	logic [7:0] owner_priority;
	logic priority_changed;

	sem_scoreboard board = new();
	int cycle_count = 0;
	int requests = 0;
	int writes = 0;
	logic [7:0] live_ids[$];
	logic [15:0] live_gens[$];

	counting_semaphore_priority_waiters dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("timeout");
			$display("counting_semaphore_priority_waiters_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check_result('{status, woken_valid, woken_task, owner_valid,
				owner_task, owner_priority, priority_changed});

	task automatic issue(logic [1:0] op, logic [7:0] id, logic [15:0] gen,
			logic [7:0] pr);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		@(negedge clk);
		repeat (gap) @(negedge clk);
		operation <= op;
		task_id <= id;
		task_generation <= gen;
		task_priority <= pr;
		start <= 1;
		do @(posedge clk); while (busy);
		board.note_request(op, id, gen, pr);
		requests++;
		if (op == OP_WAIT) begin
			live_ids.push_back(id);
			live_gens.push_back(gen);
			if (live_ids.size() > 40) begin
				void'(live_ids.pop_front());
				void'(live_gens.pop_front());
			end
		end
		@(negedge clk);
		start <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		writes++;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_request();
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			issue(OP_WAIT, 8'($urandom), 16'($urandom), 8'($urandom));
		end else if (pick < 50) begin
			issue(OP_TRY, 8'($urandom), 16'($urandom), 8'($urandom));
		end else if (pick < 80) begin
			issue(OP_POST, 8'($urandom), 16'($urandom), 8'($urandom));
		end else if (pick < 92 && live_ids.size() > 0) begin
			k = $urandom_range(0, live_ids.size() - 1);
			issue(OP_CANCEL, live_ids[k], live_gens[k], 8'($urandom));
		end else begin
			issue(OP_CANCEL, 8'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [15:0] init_pick, max_pick;
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: owner, inheritance, full table, saturation, cancel
		write_reg(REG_INIT, 16'd1);
		issue(OP_WAIT, 8'hff, 16'hffff, 8'd0);
		for (int i = 0; i < 17; i++)
			issue(OP_WAIT, 8'(i), 16'(i * 4099), (i == 5) ? 8'hff : 8'(i * 13));
		issue(OP_CANCEL, 8'd3, 16'd12297, 8'h00);
		issue(OP_CANCEL, 8'd3, 16'd0, 8'h00);
		issue(OP_TRY, 8'h00, 16'h0000, 8'hff);
		for (int i = 0; i < 17; i++)
			issue(OP_POST, 8'h00, 16'h0000, 8'h00);
		issue(OP_POST, 8'haa, 16'h5555, 8'h55);
		issue(OP_TRY, 8'h55, 16'haaaa, 8'haa);
		drain();
		write_reg(REG_MAX, 16'hffff);
		write_reg(REG_INIT, 16'hffff);
		issue(OP_POST, 8'h01, 16'h0001, 8'h01);
		issue(OP_TRY, 8'h01, 16'h0001, 8'h01);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: begin init_pick = 16'd0; max_pick = 16'd0; end
				1: begin
					init_pick = 16'($urandom_range(0, 3));
					max_pick = 16'($urandom_range(1, 4));
				end
				2: begin init_pick = 16'hffff; max_pick = 16'hffff; end
				default: begin
					init_pick = 16'($urandom_range(0, 2));
					max_pick = 16'($urandom);
				end
			endcase
			write_reg(REG_PIP, 16'(phase % 3 != 2));
			write_reg(REG_MAX, max_pick);
			write_reg(REG_INIT, init_pick);
			live_ids.delete();
			live_gens.delete();
			for (int n = 0; n < 95; n++)
				random_request();
			drain();
		end

		$display("covered %0d requests, %0d register writes, %0d result words",
			requests, writes, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("counting_semaphore_priority_waiters_tb: PASS");
		else
			$display("counting_semaphore_priority_waiters_tb: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/csem_pkg.sv
rtl/core/csem_table.sv
rtl/core/counting_semaphore_priority_waiters.sv
test/counting_semaphore_priority_waiters_tb.sv
